// ===== rtl/bcs_pkg.sv =====
// Package with the shared types, codes and constants of the bending cell cycle sequencer.
`default_nettype none

package bcs_pkg;

    // Default width of each stage timer.
    localparam int DEFAULT_TIMER_BITS = 16;

    // Number of stage timers and the width of their length registers.
    localparam int NUM_TIMERS = 7;
    localparam int LEN_BITS   = 16;
    localparam int MODE_BITS  = 31;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    // Timer indexes; each timer also uses the length register of the same index.
    localparam int T_START = 0;
    localparam int T_CUT   = 1;
    localparam int T_BEND1 = 2;
    localparam int T_BEND2 = 3;
    localparam int T_LON   = 4;
    localparam int T_LOFF  = 5;
    localparam int T_EJECT = 6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_START_WAIT = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CUT_WAIT   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BEND1_WAIT = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_BEND2_WAIT = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_LASER_ON   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_LASER_OFF  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_EJECT      = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_MODE       = 3'd7;

    // Request function codes.
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_STOP  = 2'd2;

    // Actuator level bit positions.
    localparam int LV_CUT   = 0;
    localparam int LV_BEND1 = 1;
    localparam int LV_BEND2 = 2;
    localparam int LV_LASER = 3;
    localparam int LV_EJECT = 4;

    // Mode word bit positions.
    localparam int MODE_SEPARATE = 5;
    localparam int MODE_SINGLE   = 6;

    // Sequencer phases.
    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_MOVE      = 4'd1,
        PH_CUT       = 4'd2,
        PH_BEND_ONE  = 4'd3,
        PH_BEND_TWO  = 4'd4,
        PH_LASER_ON  = 4'd5,
        PH_LASER_OFF = 4'd6,
        PH_RELEASE   = 4'd7,
        PH_EJECT_ON  = 4'd8,
        PH_EJECT_OFF = 4'd9
    } phase_t;

    // Input request payload.
    typedef struct packed {
        logic [1:0] func;
        logic       motors_idle;
    } in_item_t;

    // Result payload.
    typedef struct packed {
        logic        cut_out;
        logic        bend_one_out;
        logic        bend_two_out;
        logic        laser_out;
        logic        eject_out;
        logic        begin_moves;
        logic        halt_motors;
        logic        idle_waiting;
        logic        running;
        logic [3:0]  phase;
        logic [15:0] products_done;
    } out_item_t;

    // Timer control from the sequencer core to the timer bank.
    typedef struct packed {
        logic                  tick;
        logic [NUM_TIMERS-1:0] restart;
    } tmr_ctrl_t;

    typedef logic [NUM_TIMERS-1:0][LEN_BITS-1:0] len_array_t;

endpackage

`default_nettype wire

// ===== rtl/bcs_cfg_regs.sv =====
// Configuration register file: seven stage lengths and the mode word.
`default_nettype none

module bcs_cfg_regs
    import bcs_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     wr_en,
    input  wire logic [CFG_IDX_BITS-1:0]  wr_index,
    input  wire logic [CFG_DATA_BITS-1:0] wr_data,
    output len_array_t                    timer_len,
    output logic [MODE_BITS-1:0]          mode_word
);

    len_array_t           len_reg;
    logic [MODE_BITS-1:0] mode_reg;

    // Register writes; every register resets to zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg  <= '0;
            mode_reg <= '0;
        end else if (wr_en) begin
            unique case (wr_index)
                REG_MODE: begin
                    mode_reg <= wr_data[MODE_BITS-1:0];
                end
                default: begin
                    len_reg[wr_index] <= wr_data[LEN_BITS-1:0];
                end
            endcase
        end
    end

    assign timer_len = len_reg;
    assign mode_word = mode_reg;

endmodule

`default_nettype wire

// ===== rtl/bcs_timer_bank.sv =====
// Bank of seven saturating stage timers with expiry compare against live lengths.
`default_nettype none

module bcs_timer_bank
    import bcs_pkg::*;
#(
    parameter int TIMER_BITS = DEFAULT_TIMER_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire tmr_ctrl_t             ctrl,
    input  wire len_array_t            timer_len,
    output logic [NUM_TIMERS-1:0]      expired
);

    localparam int CMP_BITS = (TIMER_BITS > LEN_BITS) ? TIMER_BITS : LEN_BITS;
    localparam logic [TIMER_BITS-1:0] TMAX = '1;

    logic [TIMER_BITS-1:0] cnt_reg [NUM_TIMERS];
    logic [TIMER_BITS-1:0] cnt_inc [NUM_TIMERS];

    // Advanced count of each timer and its expiry; a saturated count always counts as expired.
    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_tmr
        assign cnt_inc[g] = (cnt_reg[g] == TMAX) ? cnt_reg[g] : cnt_reg[g] + 1'b1;
        assign expired[g] = (CMP_BITS'(cnt_inc[g]) >= CMP_BITS'(timer_len[g]))
                            || (cnt_inc[g] == TMAX);
    end

    // Timers leave reset expired; on a tick they advance, or clear when restarted.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                cnt_reg[i] <= TMAX;
            end
        end else if (ctrl.tick) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                cnt_reg[i] <= ctrl.restart[i] ? '0 : cnt_inc[i];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bcs_step_core.sv =====
// Sequencer core: phase machine, start and stop flags, pulse and product counters.
`default_nettype none

module bcs_step_core
    import bcs_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  fire,
    input  wire in_item_t              item,
    input  wire logic [MODE_BITS-1:0]  mode_word,
    input  wire logic [NUM_TIMERS-1:0] expired,
    output tmr_ctrl_t                  tmr_ctrl,
    output out_item_t                  result
);

    phase_t      phase_reg, phase_next;
    logic        started_reg, started_next;
    logic        stop_pend_reg, stop_pend_next;
    logic [7:0]  pulses_reg, pulses_next;
    logic [15:0] tally_reg, tally_next;
    logic [4:0]  levels_reg, levels_next;
    logic        begin_pulse;
    logic        halt_pulse;

    logic [4:0]  byp;
    logic        separate;
    logic        single;
    logic [7:0]  npulses;
    logic [15:0] batch;
    logic        tick;
    logic [15:0] tally_inc;
    logic        end_stop;

    // Mode word fields.
    assign byp      = mode_word[4:0];
    assign separate = mode_word[MODE_SEPARATE];
    assign single   = mode_word[MODE_SINGLE];
    assign npulses  = mode_word[14:7];
    assign batch    = mode_word[30:15];

    assign tick      = fire && (item.func == FUNC_TICK);
    assign tally_inc = (tally_reg == 16'hFFFF) ? tally_reg : tally_reg + 16'd1;
    // The cycle ends in a stop on a pending stop, single-cycle mode or a full batch.
    assign end_stop  = stop_pend_reg || single || ((batch != 16'd0) && (tally_inc >= batch));

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        if (tick) begin
            unique case (phase_reg)
                PH_IDLE: begin
                    if (started_reg) phase_next = PH_MOVE;
                end
                PH_MOVE: begin
                    if (item.motors_idle) phase_next = PH_CUT;
                end
                PH_CUT: begin
                    if (byp[0] || expired[T_START]) phase_next = PH_BEND_ONE;
                end
                PH_BEND_ONE: begin
                    if (byp[1] || expired[T_CUT]) phase_next = PH_BEND_TWO;
                end
                PH_BEND_TWO: begin
                    if (byp[2] || expired[T_BEND1]) phase_next = PH_LASER_ON;
                end
                PH_LASER_ON: begin
                    if (byp[3]) begin
                        phase_next = PH_RELEASE;
                    end else if (expired[T_BEND2] && expired[T_LOFF]) begin
                        phase_next = PH_LASER_OFF;
                    end
                end
                PH_LASER_OFF: begin
                    if (expired[T_LON]) begin
                        phase_next = (pulses_reg < npulses) ? PH_LASER_ON : PH_RELEASE;
                    end
                end
                PH_RELEASE: begin
                    if (expired[T_LOFF]) phase_next = PH_EJECT_ON;
                end
                PH_EJECT_ON: begin
                    if (byp[4] || expired[T_EJECT]) phase_next = PH_EJECT_OFF;
                end
                PH_EJECT_OFF: begin
                    if (expired[T_EJECT]) begin
                        if (!end_stop || started_reg) phase_next = PH_IDLE;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Flags, counters, actuator levels, timer restarts and pulses.
    always_comb begin
        started_next   = started_reg;
        stop_pend_next = stop_pend_reg;
        pulses_next    = pulses_reg;
        tally_next     = tally_reg;
        levels_next    = levels_reg;
        tmr_ctrl.tick    = tick;
        tmr_ctrl.restart = '0;
        begin_pulse    = 1'b0;
        halt_pulse     = 1'b0;
        if (fire) begin
            case (item.func)
                FUNC_START: begin
                    started_next = 1'b1;
                end
                FUNC_STOP: begin
                    if (started_reg) stop_pend_next = 1'b1;
                end
                default: begin
                end
            endcase
        end
        if (tick) begin
            unique case (phase_reg)
                PH_IDLE: begin
                    if (started_reg) begin
                        pulses_next = '0;
                        begin_pulse = 1'b1;
                    end
                end
                PH_MOVE: begin
                    if (item.motors_idle) tmr_ctrl.restart[T_START] = 1'b1;
                end
                PH_CUT: begin
                    if (byp[0]) begin
                        tmr_ctrl.restart[T_CUT] = 1'b1;
                    end else if (expired[T_START]) begin
                        levels_next[LV_CUT] = 1'b1;
                        tmr_ctrl.restart[T_CUT] = 1'b1;
                    end
                end
                PH_BEND_ONE: begin
                    if (byp[1]) begin
                        tmr_ctrl.restart[T_BEND1] = 1'b1;
                    end else if (expired[T_CUT]) begin
                        levels_next[LV_BEND1] = 1'b1;
                        // A joint bend drives both and leaves the bend-one timer alone.
                        if (separate) begin
                            tmr_ctrl.restart[T_BEND1] = 1'b1;
                        end else begin
                            levels_next[LV_BEND2] = 1'b1;
                        end
                    end
                end
                PH_BEND_TWO: begin
                    if (byp[2]) begin
                        tmr_ctrl.restart[T_BEND2] = 1'b1;
                    end else if (expired[T_BEND1]) begin
                        if (separate) levels_next[LV_BEND2] = 1'b1;
                        tmr_ctrl.restart[T_BEND2] = 1'b1;
                    end
                end
                PH_LASER_ON: begin
                    if (byp[3]) begin
                        tmr_ctrl.restart[T_LOFF] = 1'b1;
                    end else if (expired[T_BEND2] && expired[T_LOFF]) begin
                        levels_next[LV_LASER] = 1'b1;
                        if (pulses_reg != 8'hFF) pulses_next = pulses_reg + 8'd1;
                        tmr_ctrl.restart[T_LON] = 1'b1;
                    end
                end
                PH_LASER_OFF: begin
                    if (expired[T_LON]) begin
                        levels_next[LV_LASER] = 1'b0;
                        tmr_ctrl.restart[T_LOFF] = 1'b1;
                    end
                end
                PH_RELEASE: begin
                    if (expired[T_LOFF]) begin
                        levels_next[LV_CUT]   = 1'b0;
                        levels_next[LV_BEND1] = 1'b0;
                        levels_next[LV_BEND2] = 1'b0;
                        tmr_ctrl.restart[T_EJECT] = 1'b1;
                    end
                end
                PH_EJECT_ON: begin
                    if (!byp[4] && expired[T_EJECT]) begin
                        levels_next[LV_EJECT] = 1'b1;
                        tmr_ctrl.restart[T_EJECT] = 1'b1;
                    end
                end
                PH_EJECT_OFF: begin
                    if (expired[T_EJECT]) begin
                        if (!byp[4]) levels_next[LV_EJECT] = 1'b0;
                        tally_next = tally_inc;
                        // A pending stop is consumed even when it ends the cycle.
                        if (stop_pend_reg) stop_pend_next = 1'b0;
                        if (end_stop && started_reg) begin
                            halt_pulse   = 1'b1;
                            started_next = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // State registers, updated once per request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            started_reg   <= 1'b0;
            stop_pend_reg <= 1'b0;
            pulses_reg    <= '0;
            tally_reg     <= '0;
            levels_reg    <= '0;
        end else if (fire) begin
            phase_reg     <= phase_next;
            started_reg   <= started_next;
            stop_pend_reg <= stop_pend_next;
            pulses_reg    <= pulses_next;
            tally_reg     <= tally_next;
            levels_reg    <= levels_next;
        end
    end

    // Result describes the block after this request.
    always_comb begin
        result.cut_out       = levels_next[LV_CUT];
        result.bend_one_out  = levels_next[LV_BEND1];
        result.bend_two_out  = levels_next[LV_BEND2];
        result.laser_out     = levels_next[LV_LASER];
        result.eject_out     = levels_next[LV_EJECT];
        result.begin_moves   = begin_pulse;
        result.halt_motors   = halt_pulse;
        result.idle_waiting  = (phase_next == PH_IDLE) && !started_next;
        result.running       = started_next;
        result.phase         = phase_next;
        result.products_done = tally_next;
    end

    // A begin pulse always leaves the block waiting for the moves with a fresh burst count.
    a_begin_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && begin_pulse |=> (phase_reg == PH_MOVE) && (pulses_reg == 8'd0))
        else $error("begin pulse did not enter the move phase");

    // A halt pulse always leaves the machine stopped in the idle phase.
    a_halt_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && halt_pulse |=> !started_reg && (phase_reg == PH_IDLE) && !stop_pend_reg)
        else $error("halt pulse did not stop the machine");

    // The laser is only ever driven while a pulse is timing out.
    a_laser_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        levels_reg[LV_LASER] |-> (phase_reg == PH_LASER_OFF))
        else $error("laser driven outside its pulse phase");

endmodule

`default_nettype wire

// ===== rtl/bending_cell_cycle_sequencer.sv =====
// Top level of the bending cell cycle sequencer: request and result registers around the core.
//
//  Channel   Ports                               Direction  Payload
//  request   s_valid, s_ready, s_item            in         in_item_t (func, motors_idle)
//  result    m_valid, m_ready, m_item            out        out_item_t (levels, pulses, status)
//  config    cfg_valid, cfg_ready, cfg_index,    in         register index and write data
//            cfg_data
//
//  Each request gives one result, which passes from the request register into the result register;
//  one request can be accepted every cycle while the result register is free or draining, set by
//  the single step of the phase machine between request and result register.
//  Reset is synchronous and active low; the stage timers leave reset expired.
//  A stalled result holds in its register while one more request is taken into the request
//  register; configuration writes are taken in every cycle.
`default_nettype none

module bending_cell_cycle_sequencer
    import bcs_pkg::*;
#(
    parameter int TIMER_BITS = DEFAULT_TIMER_BITS
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire in_item_t                 s_item,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output out_item_t                     m_item,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    logic                  in_valid_reg;
    in_item_t              in_item_reg;
    logic                  out_valid_reg;
    out_item_t             out_item_reg;
    logic                  out_free;
    logic                  fire;
    len_array_t            timer_len;
    logic [MODE_BITS-1:0]  mode_word;
    logic [NUM_TIMERS-1:0] expired;
    tmr_ctrl_t             tmr_ctrl;
    out_item_t             result;

    // Handshake: the request stage moves on whenever the result register is free or draining.
    assign out_free  = !out_valid_reg || m_ready;
    assign fire      = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    // Request register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_item_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    // Configuration registers.
    bcs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (cfg_valid && cfg_ready),
        .wr_index  (cfg_index),
        .wr_data   (cfg_data),
        .timer_len (timer_len),
        .mode_word (mode_word)
    );

    // Stage timers.
    bcs_timer_bank #(
        .TIMER_BITS (TIMER_BITS)
    ) u_timers (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (tmr_ctrl),
        .timer_len (timer_len),
        .expired   (expired)
    );

    // Phase machine and counters.
    bcs_step_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .item      (in_item_reg),
        .mode_word (mode_word),
        .expired   (expired),
        .tmr_ctrl  (tmr_ctrl),
        .result    (result)
    );

    // A held request must stay put until the result register can take its result.
    a_req_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_item_reg))
        else $error("request register lost a held request");

endmodule

`default_nettype wire

// ===== tb/bending_cell_cycle_sequencer_test.sv =====
// Self-checking testbench for the bending cell cycle sequencer.
`timescale 1ns / 1ps

module bending_cell_cycle_sequencer_test;
    import bcs_pkg::*;

    localparam int          TB_TIMER_BITS = DEFAULT_TIMER_BITS;
    localparam logic [1:0]  FUNC_SPARE    = 2'd3;
    localparam int          LIMIT_CYCLES  = 4_000_000;
    localparam logic [TB_TIMER_BITS-1:0] TMR_MAX = '1;

    // Receiver stall styles, picked anew whenever the stall counter reaches its top value.
    typedef enum logic [1:0] {
        DRAIN_FREE   = 2'd0,
        DRAIN_COIN   = 2'd1,
        DRAIN_SPARSE = 2'd2,
        DRAIN_BLOCKY = 2'd3
    } stall_style_t;

    // A result typed in by hand, or a marker to use the prediction.
    typedef struct packed {
        logic      fixed;
        out_item_t want;
    } pinned_t;

    typedef struct packed {
        in_item_t  req;
        logic      fixed;
        out_item_t want;
    } script_row_t;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_valid   = 1'b0;
    logic                     s_ready;
    in_item_t                 s_item    = '0;
    logic                     m_valid;
    logic                     m_ready   = 1'b0;
    out_item_t                m_item;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

    // Shadow of the sequencer state and its registers.
    phase_t                   ph;
    logic                     started;
    logic                     stop_pend;
    logic [7:0]               pulses;
    logic [15:0]              tally;
    logic [4:0]               levels;
    logic [TB_TIMER_BITS-1:0] elapsed [NUM_TIMERS];
    logic [LEN_BITS-1:0]      len_reg [NUM_TIMERS];
    logic [MODE_BITS-1:0]     mode_reg;

    out_item_t   status_due_q [$];
    pinned_t     pinned_q [$];
    script_row_t directed_script [19];
    out_item_t   predicted;
    out_item_t   want;
    pinned_t     pin;

    int           mismatches  = 0;
    int           cycle_count = 0;
    int           burst_left  = 0;
    bit           fast_run    = 1'b0;
    stall_style_t stall_style = DRAIN_FREE;
    logic [5:0]   stall_tick  = '0;

    bending_cell_cycle_sequencer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Runaway guard.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what, input int got_v, input int want_v);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got_v,
                 want_v);
        mismatches++;
    endtask

    function automatic logic timer_done(input int t);
        return elapsed[t] >= len_reg[t] || elapsed[t] == TMR_MAX;
    endfunction

    // One request applied to the shadow state; returns the status after it.
    function automatic out_item_t step_sequencer(input in_item_t req);
        out_item_t   res;
        logic [4:0]  skip;
        logic        split;
        logic        one_shot;
        logic        begin_pulse;
        logic        halt_pulse;
        logic        end_run;
        logic [7:0]  pulse_target;
        logic [15:0] batch_size;
        int          t;
        skip         = mode_reg[4:0];
        split        = mode_reg[MODE_SEPARATE];
        one_shot     = mode_reg[MODE_SINGLE];
        pulse_target = mode_reg[14:7];
        batch_size   = mode_reg[30:15];
        begin_pulse  = 1'b0;
        halt_pulse   = 1'b0;
        case (req.func)
            FUNC_TICK: begin
                for (t = 0; t < NUM_TIMERS; t++) begin
                    if (elapsed[t] != TMR_MAX) elapsed[t] = elapsed[t] + 1'b1;
                end
                // Bypass bits share the positions of the actuator level bits.
                case (ph)
                    PH_IDLE: begin
                        if (started) begin
                            pulses      = '0;
                            begin_pulse = 1'b1;
                            ph          = PH_MOVE;
                        end
                    end
                    PH_MOVE: begin
                        if (req.motors_idle) begin
                            elapsed[T_START] = '0;
                            ph               = PH_CUT;
                        end
                    end
                    PH_CUT: begin
                        if (skip[LV_CUT] || timer_done(T_START)) begin
                            if (!skip[LV_CUT]) levels[LV_CUT] = 1'b1;
                            elapsed[T_CUT] = '0;
                            ph             = PH_BEND_ONE;
                        end
                    end
                    PH_BEND_ONE: begin
                        if (skip[LV_BEND1]) begin
                            elapsed[T_BEND1] = '0;
                            ph               = PH_BEND_TWO;
                        end else if (timer_done(T_CUT)) begin
                            // Joint bending drives both bends and leaves the bend-one timer.
                            levels[LV_BEND1] = 1'b1;
                            if (split) elapsed[T_BEND1] = '0;
                            else levels[LV_BEND2] = 1'b1;
                            ph = PH_BEND_TWO;
                        end
                    end
                    PH_BEND_TWO: begin
                        if (skip[LV_BEND2] || timer_done(T_BEND1)) begin
                            if (!skip[LV_BEND2] && split) levels[LV_BEND2] = 1'b1;
                            elapsed[T_BEND2] = '0;
                            ph               = PH_LASER_ON;
                        end
                    end
                    PH_LASER_ON: begin
                        if (skip[LV_LASER]) begin
                            elapsed[T_LOFF] = '0;
                            ph              = PH_RELEASE;
                        end else if (timer_done(T_BEND2) && timer_done(T_LOFF)) begin
                            levels[LV_LASER] = 1'b1;
                            if (pulses != 8'hFF) pulses = pulses + 1'b1;
                            elapsed[T_LON] = '0;
                            ph             = PH_LASER_OFF;
                        end
                    end
                    PH_LASER_OFF: begin
                        if (timer_done(T_LON)) begin
                            levels[LV_LASER] = 1'b0;
                            elapsed[T_LOFF]  = '0;
                            ph = (pulses < pulse_target) ? PH_LASER_ON : PH_RELEASE;
                        end
                    end
                    PH_RELEASE: begin
                        if (timer_done(T_LOFF)) begin
                            levels[LV_CUT]   = 1'b0;
                            levels[LV_BEND1] = 1'b0;
                            levels[LV_BEND2] = 1'b0;
                            elapsed[T_EJECT] = '0;
                            ph               = PH_EJECT_ON;
                        end
                    end
                    PH_EJECT_ON: begin
                        if (skip[LV_EJECT]) begin
                            ph = PH_EJECT_OFF;
                        end else if (timer_done(T_EJECT)) begin
                            levels[LV_EJECT] = 1'b1;
                            elapsed[T_EJECT] = '0;
                            ph               = PH_EJECT_OFF;
                        end
                    end
                    PH_EJECT_OFF: begin
                        if (timer_done(T_EJECT)) begin
                            if (!skip[LV_EJECT]) levels[LV_EJECT] = 1'b0;
                            if (tally != 16'hFFFF) tally = tally + 1'b1;
                            end_run = stop_pend || one_shot ||
                                      (batch_size != 0 && tally >= batch_size);
                            stop_pend = 1'b0;
                            if (!end_run) begin
                                ph = PH_IDLE;
                            end else if (started) begin
                                halt_pulse = 1'b1;
                                started    = 1'b0;
                                ph         = PH_IDLE;
                            end
                        end
                    end
                    default: begin
                        ph = PH_IDLE;
                    end
                endcase
            end
            FUNC_START: begin
                started = 1'b1;
            end
            FUNC_STOP: begin
                if (started) stop_pend = 1'b1;
            end
            default: begin
                // The spare code changes nothing.
            end
        endcase
        res               = '0;
        res.cut_out       = levels[LV_CUT];
        res.bend_one_out  = levels[LV_BEND1];
        res.bend_two_out  = levels[LV_BEND2];
        res.laser_out     = levels[LV_LASER];
        res.eject_out     = levels[LV_EJECT];
        res.begin_moves   = begin_pulse;
        res.halt_motors   = halt_pulse;
        res.idle_waiting  = (ph == PH_IDLE) && !started;
        res.running       = started;
        res.phase         = ph;
        res.products_done = tally;
        return res;
    endfunction

    // Status with every actuator off, for rows whose result is obvious.
    function automatic out_item_t at_rest(input logic begin_p, input logic halt_p,
                                          input logic waiting, input logic run,
                                          input phase_t ph_v, input logic [15:0] made);
        out_item_t res;
        res               = '0;
        res.begin_moves   = begin_p;
        res.halt_motors   = halt_p;
        res.idle_waiting  = waiting;
        res.running       = run;
        res.phase         = ph_v;
        res.products_done = made;
        return res;
    endfunction

    function automatic script_row_t row(input logic [1:0] func, input logic idle,
                                        input logic fixed, input out_item_t res);
        script_row_t r;
        r.req.func        = func;
        r.req.motors_idle = idle;
        r.fixed           = fixed;
        r.want            = res;
        return r;
    endfunction

    // Request monitor: predict the status of every accepted request.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            predicted = step_sequencer(s_item);
            pin       = pinned_q.pop_front();
            status_due_q.push_back(pin.fixed ? pin.want : predicted);
        end
    end

    // Configuration monitor: keep the shadow registers in step with the writes.
    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) begin
            if (cfg_index == REG_MODE) mode_reg = cfg_data[MODE_BITS-1:0];
            else len_reg[cfg_index] = cfg_data[LEN_BITS-1:0];
        end
    end

    // Result monitor: compare each status with the oldest one due.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (status_due_q.size() == 0) begin
                flag_mismatch("status with nothing outstanding", m_item, 0);
            end else begin
                want = status_due_q.pop_front();
                if (m_item.cut_out !== want.cut_out)
                    flag_mismatch("cut_out", m_item.cut_out, want.cut_out);
                if (m_item.bend_one_out !== want.bend_one_out)
                    flag_mismatch("bend_one_out", m_item.bend_one_out, want.bend_one_out);
                if (m_item.bend_two_out !== want.bend_two_out)
                    flag_mismatch("bend_two_out", m_item.bend_two_out, want.bend_two_out);
                if (m_item.laser_out !== want.laser_out)
                    flag_mismatch("laser_out", m_item.laser_out, want.laser_out);
                if (m_item.eject_out !== want.eject_out)
                    flag_mismatch("eject_out", m_item.eject_out, want.eject_out);
                if (m_item.begin_moves !== want.begin_moves)
                    flag_mismatch("begin_moves", m_item.begin_moves, want.begin_moves);
                if (m_item.halt_motors !== want.halt_motors)
                    flag_mismatch("halt_motors", m_item.halt_motors, want.halt_motors);
                if (m_item.idle_waiting !== want.idle_waiting)
                    flag_mismatch("idle_waiting", m_item.idle_waiting, want.idle_waiting);
                if (m_item.running !== want.running)
                    flag_mismatch("running", m_item.running, want.running);
                if (m_item.phase !== want.phase)
                    flag_mismatch("phase", m_item.phase, want.phase);
                if (m_item.products_done !== want.products_done)
                    flag_mismatch("products_done", m_item.products_done, want.products_done);
            end
        end
    end

    // Receiver back-pressure on a pattern of its own.
    always @(posedge aclk) begin
        stall_tick <= stall_tick + 1'b1;
        if (stall_tick == 6'd63) stall_style <= stall_style_t'($urandom_range(0, 3));
        if (fast_run) begin
            m_ready <= 1'b1;
        end else begin
            case (stall_style)
                DRAIN_FREE:   m_ready <= 1'b1;
                DRAIN_COIN:   m_ready <= $urandom_range(0, 1);
                DRAIN_SPARSE: m_ready <= (stall_tick[1:0] == 2'b00);
                default:      m_ready <= (stall_tick[3:0] < 4'd10);
            endcase
        end
    end

    // Drive one request and hold it until accepted; gaps fall between bursts.
    task automatic send_request(input in_item_t req, input logic fixed, input out_item_t res);
        pinned_q.push_back({fixed, res});
        s_item  <= req;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (!fast_run) begin
            if (burst_left == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                burst_left = $urandom_range(0, 30);
            end else begin
                burst_left = burst_left - 1;
            end
        end
    endtask

    // A start request followed by ticks only, or by mostly ticks with starts, stops and spare codes mixed in.
    task automatic send_stream(input int count, input bit ticks_only);
        in_item_t req;
        int       pick;
        int       k;
        for (k = 0; k < count; k++) begin
            pick            = $urandom_range(0, 99);
            req.motors_idle = ($urandom_range(0, 7) != 0);
            if (k == 0) req.func = FUNC_START;
            else if (ticks_only || pick < 78) req.func = FUNC_TICK;
            else if (pick < 88) req.func = FUNC_START;
            else if (pick < 96) req.func = FUNC_STOP;
            else req.func = FUNC_SPARE;
            send_request(req, 1'b0, '0);
        end
    endtask

    // Stop sending and wait until every status has come back.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (status_due_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write all eight registers, in a rotated order, for one setting of the run.
    task automatic configure(input int setting);
        logic [31:0]             plan [8];
        logic [15:0]             batch;
        logic [7:0]              shots;
        logic [4:0]              skip;
        logic                    one_shot;
        logic                    split;
        logic [CFG_IDX_BITS-1:0] idx;
        int                      first;
        int                      k;
        for (k = 0; k < 8; k++) begin
            plan[k]        = $urandom;
            plan[k][15:0]  = $urandom_range(0, 3);
        end
        batch    = '0;
        shots    = $urandom_range(0, 4);
        skip     = $urandom_range(0, 31);
        one_shot = ($urandom_range(0, 3) == 0);
        split    = $urandom_range(0, 1);
        case (setting)
            0: begin
                shots    = 8'd2;
                skip     = '0;
                one_shot = 1'b0;
                split    = 1'b1;
            end
            1: begin
                batch = tally + $urandom_range(1, 3);
            end
            2: begin
                // The first five lengths and every mode field at their top values; the long stages are all bypassed.
                for (k = 0; k < REG_LASER_OFF; k++) plan[k] = 32'hFFFF_FFFF;
                plan[REG_LASER_OFF] = '0;
                plan[REG_EJECT]     = '0;
                batch    = 16'hFFFF;
                shots    = 8'hFF;
                skip     = 5'h1F;
                one_shot = 1'b1;
                split    = 1'b1;
            end
            3: begin
                for (k = 0; k < REG_MODE; k++) plan[k] = '0;
                shots    = '0;
                skip     = '0;
                one_shot = 1'b0;
                split    = 1'b0;
            end
            4: begin
                // Longest laser burst, with short stages.
                for (k = 0; k < REG_MODE; k++) plan[k][15:0] = '0;
                shots    = 8'hFF;
                skip     = '0;
                one_shot = 1'b0;
                split    = 1'b1;
            end
            7: begin
                // Shortest possible cycle, so that whole cycles run back to back.
                for (k = 0; k < REG_MODE; k++) plan[k][15:0] = '0;
                shots    = '0;
                skip     = 5'h1F;
                one_shot = 1'b0;
            end
            default: begin
                for (k = 0; k < REG_MODE; k++) begin
                    if ($urandom_range(0, 9) == 0) plan[k][15:0] = 16'hFFFF;
                    else plan[k][15:0] = $urandom_range(0, 6);
                end
                if ($urandom_range(0, 1)) batch = tally + $urandom_range(1, 4);
            end
        endcase
        plan[REG_MODE] = {plan[REG_MODE][31], batch, shots, one_shot, split, skip};
        first = $urandom_range(0, 7);
        for (k = 0; k < 8; k++) begin
            idx        = CFG_IDX_BITS'(first + k);
            cfg_index <= idx;
            cfg_data  <= plan[idx];
            cfg_valid <= 1'b1;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int i;
        int p;
        ph        = PH_IDLE;
        started   = 1'b0;
        stop_pend = 1'b0;
        pulses    = '0;
        tally     = '0;
        levels    = '0;
        mode_reg  = '0;
        for (i = 0; i < NUM_TIMERS; i++) begin
            elapsed[i] = TMR_MAX;
            len_reg[i] = '0;
        end

        // One full cycle on the reset settings: joint bend, a single pulse
        // despite a zero count, and a stop taken at the end of the cycle.
        directed_script[0]  = row(FUNC_TICK,  1'b0, 1'b1, at_rest(0, 0, 1, 0, PH_IDLE, 0));
        directed_script[1]  = row(FUNC_SPARE, 1'b1, 1'b1, at_rest(0, 0, 1, 0, PH_IDLE, 0));
        directed_script[2]  = row(FUNC_STOP,  1'b1, 1'b1, at_rest(0, 0, 1, 0, PH_IDLE, 0));
        directed_script[3]  = row(FUNC_START, 1'b0, 1'b1, at_rest(0, 0, 0, 1, PH_IDLE, 0));
        directed_script[4]  = row(FUNC_START, 1'b1, 1'b1, at_rest(0, 0, 0, 1, PH_IDLE, 0));
        directed_script[5]  = row(FUNC_TICK,  1'b0, 1'b1, at_rest(1, 0, 0, 1, PH_MOVE, 0));
        directed_script[6]  = row(FUNC_TICK,  1'b0, 1'b0, '0);
        directed_script[7]  = row(FUNC_TICK,  1'b1, 1'b0, '0);
        directed_script[8]  = row(FUNC_TICK,  1'b1, 1'b0, '0);
        directed_script[9]  = row(FUNC_TICK,  1'b0, 1'b0, '0);
        directed_script[10] = row(FUNC_TICK,  1'b1, 1'b0, '0);
        directed_script[11] = row(FUNC_TICK,  1'b1, 1'b0, '0);
        directed_script[12] = row(FUNC_TICK,  1'b1, 1'b0, '0);
        directed_script[13] = row(FUNC_TICK,  1'b1, 1'b0, '0);
        directed_script[14] = row(FUNC_STOP,  1'b0, 1'b0, '0);
        directed_script[15] = row(FUNC_TICK,  1'b1, 1'b0, '0);
        directed_script[16] = row(FUNC_TICK,  1'b1, 1'b1, at_rest(0, 1, 1, 0, PH_IDLE, 1));
        directed_script[17] = row(FUNC_STOP,  1'b0, 1'b1, at_rest(0, 0, 1, 0, PH_IDLE, 1));
        directed_script[18] = row(FUNC_SPARE, 1'b0, 1'b1, at_rest(0, 0, 1, 0, PH_IDLE, 1));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < 19; i++)
            send_request(directed_script[i].req, directed_script[i].fixed,
                         directed_script[i].want);
        settle();

        // Random phases, each on a fresh register setting.
        for (p = 0; p < 7; p++) begin
            configure(p);
            if (p == 4) send_stream(60, 1'b1);
            else send_stream(50, 1'b0);
            settle();
        end

        // Back-to-back shortest cycles with no gaps and no stalls.
        configure(7);
        fast_run = 1'b1;
        send_stream(40, 1'b1);
        settle();
        fast_run = 1'b0;

        // Batch limits and single cycles on a last random setting.
        configure(8);
        send_stream(30, 1'b0);
        settle();
        repeat (8) @(posedge aclk);

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
